[design/pmft_pkg.sv]
package pmft_pkg;

    localparam int LOGICAL_PAGES_DEF   = 64;
    localparam int PHYSICAL_PAGES_DEF  = 128;
    localparam int PAGES_PER_BLOCK_DEF = 16;
    localparam int BLOCKS_DEF          = 8;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_COLLECT = 2'd2,
        OP_RESET   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_NO_FREE  = 2'd2
    } status_t;

    localparam logic [1:0] PG_FREE    = 2'd0;
    localparam logic [1:0] PG_VALID   = 2'd1;
    localparam logic [1:0] PG_INVALID = 2'd2;

endpackage

[design/page_mapped_flash_translation.sv]
// Channel | Handshake      | Payload
// input   | valid / stall  | opcode, logical_page, write_value, block_select
// output  | out_valid / out_stall | status ... collect_total
//
// One beat is taken at a time. A write scans for a free page (the free-page
// scan walks the page-state memory one entry per cycle), a garbage collection
// walks every page, and a read and a reset need no scan.
// Reset (rst_n) clears the map and page valid bits at once, so no sweep.
// The result is held in an output register while out_stall is high; a new
// beat is taken only once the previous result has left.
module page_mapped_flash_translation
    import pmft_pkg::*;
#(
    parameter int LOGICAL_PAGES   = LOGICAL_PAGES_DEF,
    parameter int PHYSICAL_PAGES  = PHYSICAL_PAGES_DEF,
    parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF,
    parameter int BLOCKS          = BLOCKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [1:0]  opcode,
    input  logic [5:0]  logical_page,
    input  logic signed [31:0] write_value,
    input  logic [2:0]  block_select,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [6:0]  physical_page,
    output logic signed [31:0] read_value,
    output logic [7:0]  freed_count,
    output logic [7:0]  free_total,
    output logic [7:0]  invalid_total,
    output logic [31:0] erase_count,
    output logic [31:0] write_total,
    output logic [31:0] read_total,
    output logic [31:0] collect_total
);

    localparam int LW = $clog2(LOGICAL_PAGES);
    localparam int PW = $clog2(PHYSICAL_PAGES);
    localparam int CW = $clog2(PHYSICAL_PAGES + 1);
    localparam int BW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_MAPRD = 8'b00000010,
        S_MAPWT = 8'b00000100,
        S_SCAN  = 8'b00001000,
        S_RDWT  = 8'b00010000,
        S_GC    = 8'b00100000,
        S_FIN   = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]    op_reg;
    logic [LW-1:0] lp_reg;
    logic [31:0]   wv_reg;
    logic [2:0]    bs_reg;
    logic          mvalid_reg;
    logic [PW-1:0] mpage_reg;
    logic [PW:0]   scan_reg;
    logic [PW:0]   issue_reg;
    logic [CW-1:0] free_reg, inval_reg, freed_reg;
    logic [31:0]   erases_reg [BLOCKS];
    logic [31:0]   wr_tot_reg, rd_tot_reg, gc_tot_reg;
    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [6:0]    ppage_reg;
    logic [31:0]   rval_reg;

    logic          op_reset_now;
    logic          pm_rd_en, pm_wr_en, pm_wr_data_en;
    logic [PW-1:0] pm_rd_addr, pm_wr_addr;
    logic [1:0]    pm_wr_state, pm_rd_state;
    logic [31:0]   pm_rd_data;
    logic          mm_rd_valid, mm_wr_en;
    logic [PW-1:0] mm_rd_page;
    logic [PW-1:0] scan_page;
    logic [PW:0]   gc_blk;

    assign scan_page = scan_reg[PW-1:0];
    assign gc_blk = (PW+1)'(scan_reg / PAGES_PER_BLOCK);

    pmft_page_mem #(.PHYSICAL_PAGES(PHYSICAL_PAGES)) u_page (
        .clk(clk), .rst_n(rst_n), .clear(op_reset_now),
        .rd_en(pm_rd_en), .rd_addr(pm_rd_addr),
        .rd_state(pm_rd_state), .rd_data(pm_rd_data),
        .wr_en(pm_wr_en), .wr_data_en(pm_wr_data_en), .wr_addr(pm_wr_addr),
        .wr_state(pm_wr_state), .wr_data(wv_reg)
    );

    assign op_reset_now = (state_reg == S_MAPRD) && (op_reg == OP_RESET);

    pmft_map_mem #(.LOGICAL_PAGES(LOGICAL_PAGES), .PHYSICAL_PAGES(PHYSICAL_PAGES)) u_map (
        .clk(clk), .rst_n(rst_n), .clear(op_reset_now),
        .rd_en(state_reg == S_MAPRD), .rd_addr(lp_reg),
        .rd_valid(mm_rd_valid), .rd_page(mm_rd_page),
        .wr_en(mm_wr_en), .wr_addr(lp_reg), .wr_page(scan_page)
    );

    // Scan issues one page read per cycle; the result of page scan_reg
    // appears in the cycle after issue_reg passed it.
    logic scan_hit;
    assign scan_hit = (state_reg == S_SCAN) && (issue_reg != scan_reg)
                      && (pm_rd_state == PG_FREE);
    assign pm_rd_en = (state_reg == S_SCAN) || (state_reg == S_GC)
                      || (state_reg == S_MAPWT);
    always_comb
    begin
        pm_rd_addr = issue_reg[PW-1:0];
        if (state_reg == S_MAPWT && op_reg == OP_READ)
        begin
            pm_rd_addr = mm_rd_page;
        end
    end

    logic gc_hit;
    assign gc_hit = (state_reg == S_GC) && (issue_reg != scan_reg)
                    && (pm_rd_state == PG_INVALID);

    always_comb
    begin
        pm_wr_en      = 1'b0;
        pm_wr_data_en = 1'b0;
        pm_wr_addr    = scan_page;
        pm_wr_state   = PG_FREE;
        mm_wr_en      = 1'b0;
        if (gc_hit)
        begin
            pm_wr_en = 1'b1;
        end
        else if (scan_hit)
        begin
            pm_wr_en      = 1'b1;
            pm_wr_data_en = 1'b1;
            pm_wr_state   = PG_VALID;
            mm_wr_en      = 1'b1;
        end
        else if (state_reg == S_FIN && op_reg == OP_WRITE && status_reg == ST_OK
                 && mvalid_reg)
        begin
            pm_wr_en    = 1'b1;
            pm_wr_addr  = mpage_reg;
            pm_wr_state = PG_INVALID;
        end
    end

    assign stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (valid) state_next = S_MAPRD;
            S_MAPRD: state_next = (op_reg == OP_RESET) ? S_FIN : S_MAPWT;
            S_MAPWT:
            begin
                case (op_reg)
                    OP_WRITE:   state_next = S_SCAN;
                    OP_READ:    state_next = S_RDWT;
                    OP_COLLECT: state_next = S_GC;
                    default:    state_next = S_FIN;
                endcase
            end
            S_SCAN:
                if (scan_hit || scan_reg == PW'(0) + (PW+1)'(PHYSICAL_PAGES))
                    state_next = S_FIN;
            S_GC:
                if (scan_reg == (PW+1)'(PHYSICAL_PAGES)) state_next = S_FIN;
            S_RDWT:  state_next = S_FIN;
            S_FIN:   state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && valid)
        begin
            op_reg <= opcode;
            lp_reg <= LW'(logical_page % LOGICAL_PAGES);
            wv_reg <= write_value;
            bs_reg <= block_select;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            free_reg      <= CW'(PHYSICAL_PAGES);
            inval_reg     <= '0;
            freed_reg     <= '0;
            wr_tot_reg    <= '0;
            rd_tot_reg    <= '0;
            gc_tot_reg    <= '0;
            scan_reg      <= '0;
            issue_reg     <= '0;
            mvalid_reg    <= 1'b0;
            mpage_reg     <= '0;
            status_reg    <= ST_OK;
            ppage_reg     <= '0;
            rval_reg      <= '0;
            for (int b = 0; b < BLOCKS; b++) erases_reg[b] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    status_reg <= ST_OK;
                    ppage_reg  <= '0;
                    rval_reg   <= '0;
                    freed_reg  <= '0;
                    scan_reg   <= '0;
                    issue_reg  <= '0;
                end
                S_MAPRD:
                begin
                    if (op_reg == OP_RESET)
                    begin
                        free_reg   <= CW'(PHYSICAL_PAGES);
                        inval_reg  <= '0;
                        wr_tot_reg <= '0;
                        rd_tot_reg <= '0;
                        gc_tot_reg <= '0;
                        for (int b = 0; b < BLOCKS; b++) erases_reg[b] <= '0;
                    end
                end
                S_MAPWT:
                begin
                    mvalid_reg <= mm_rd_valid;
                    mpage_reg  <= mm_rd_page;
                    if (op_reg == OP_READ && !mm_rd_valid) status_reg <= ST_UNMAPPED;
                    if (op_reg == OP_WRITE || op_reg == OP_COLLECT)
                        issue_reg <= (PW+1)'(1);
                end
                S_SCAN, S_GC:
                begin
                    if (issue_reg != (PW+1)'(PHYSICAL_PAGES)) issue_reg <= issue_reg + 1'b1;
                    if (issue_reg != scan_reg) scan_reg <= scan_reg + 1'b1;
                    if (scan_hit) ppage_reg <= 7'(scan_page);
                    if (state_reg == S_SCAN && issue_reg == scan_reg)
                        status_reg <= ST_NO_FREE;
                    if (gc_hit)
                    begin
                        freed_reg <= freed_reg + 1'b1;
                        if (gc_blk < (PW+1)'(BLOCKS))
                            erases_reg[BW'(gc_blk)] <= erases_reg[BW'(gc_blk)] + 1'b1;
                    end
                end
                S_RDWT:
                begin
                    if (status_reg == ST_OK)
                    begin
                        ppage_reg <= 7'(mpage_reg);
                        rval_reg  <= pm_rd_data;
                        rd_tot_reg <= rd_tot_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    if (op_reg == OP_WRITE && status_reg == ST_OK)
                    begin
                        free_reg   <= free_reg - 1'b1;
                        wr_tot_reg <= wr_tot_reg + 1'b1;
                        if (mvalid_reg) inval_reg <= inval_reg + 1'b1;
                    end
                    if (op_reg == OP_COLLECT)
                    begin
                        free_reg   <= free_reg + freed_reg;
                        inval_reg  <= inval_reg - freed_reg;
                        gc_tot_reg <= gc_tot_reg + 1'b1;
                    end
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (!out_stall) out_valid_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Outputs: counters are read from live registers, stable while in S_OUT.
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign physical_page = ppage_reg;
    assign read_value    = rval_reg;
    assign freed_count   = 8'(freed_reg);
    assign free_total    = 8'(free_reg);
    assign invalid_total = 8'(inval_reg);
    assign erase_count   = (32'(bs_reg) < 32'(BLOCKS)) ? erases_reg[BW'(bs_reg)] : '0;
    assign write_total   = wr_tot_reg;
    assign read_total    = rd_tot_reg;
    assign collect_total = gc_tot_reg;

endmodule

[design/pmft_page_mem.sv]
// Page state and page data memory. One synchronous port each for read and
// write, read data registered. A page counts as free until its first write
// since the last clear; the valid bits live here because the state reset must
// take effect at once.
module pmft_page_mem
    import pmft_pkg::*;
#(
    parameter int PHYSICAL_PAGES = PHYSICAL_PAGES_DEF,
    localparam int PW = $clog2(PHYSICAL_PAGES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          rd_en,
    input  logic [PW-1:0] rd_addr,
    output logic [1:0]    rd_state,
    output logic [31:0]   rd_data,
    input  logic          wr_en,
    input  logic          wr_data_en,
    input  logic [PW-1:0] wr_addr,
    input  logic [1:0]    wr_state,
    input  logic [31:0]   wr_data
);

    logic [1:0]  state_mem [PHYSICAL_PAGES];
    logic [31:0] data_mem  [PHYSICAL_PAGES];
    logic [PHYSICAL_PAGES-1:0] touched_reg;
    logic [1:0]  state_q;
    logic [31:0] data_q;
    logic        hit_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[wr_addr] <= wr_state;
        end
        if (wr_data_en)
        begin
            data_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            state_q <= state_mem[rd_addr];
            data_q  <= data_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touched_reg <= '0;
            hit_q       <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                touched_reg <= '0;
            end
            else if (wr_en)
            begin
                touched_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_q <= touched_reg[rd_addr];
            end
        end
    end

    // Data of a page only read while the page is valid, so written since clear.
    assign rd_state = hit_q ? state_q : PG_FREE;
    assign rd_data  = data_q;

endmodule

[design/pmft_map_mem.sv]
// Logical-to-physical map with a valid bit per entry.
module pmft_map_mem
    import pmft_pkg::*;
#(
    parameter int LOGICAL_PAGES  = LOGICAL_PAGES_DEF,
    parameter int PHYSICAL_PAGES = PHYSICAL_PAGES_DEF,
    localparam int LW = $clog2(LOGICAL_PAGES),
    localparam int PW = $clog2(PHYSICAL_PAGES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          rd_en,
    input  logic [LW-1:0] rd_addr,
    output logic          rd_valid,
    output logic [PW-1:0] rd_page,
    input  logic          wr_en,
    input  logic [LW-1:0] wr_addr,
    input  logic [PW-1:0] wr_page
);

    logic [PW-1:0] page_mem [LOGICAL_PAGES];
    logic [LOGICAL_PAGES-1:0] valid_reg;
    logic [PW-1:0] page_q;
    logic          valid_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            page_mem[wr_addr] <= wr_page;
        end
        if (rd_en)
        begin
            page_q <= page_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            valid_q   <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                valid_q <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_valid = valid_q;
    assign rd_page  = page_q;

endmodule

[design/pmft_checker.sv]
module pmft_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [7:0] free_total,
    input logic [7:0] invalid_total
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result dropped while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stall)
        else $error("beat taken while result pending");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !stall |=> stall)
        else $error("second beat taken while busy");

    a_pages: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, free_total} + {1'b0, invalid_total}) <= 9'd128)
        else $error("page counts exceed the device");

endmodule

bind page_mapped_flash_translation pmft_checker u_chk (
    .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .free_total(free_total), .invalid_total(invalid_total)
);
